[design/vliw_bundle_slot_executor_defines.svh]
// Assertion macros used by the bound checker.
`ifndef VLIW_BUNDLE_SLOT_EXECUTOR_DEFINES_SVH
`define VLIW_BUNDLE_SLOT_EXECUTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define VBSE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define VBSE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/vbse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package vbse_pkg;

	localparam int REG_COUNT = 64;
	localparam int MAX_SLOTS = 8;
	localparam int DATA_W    = 64;
	localparam int FIELD_W   = 16;
	localparam int RA_W      = $clog2(REG_COUNT);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
	localparam int PI_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	// Operation codes
	localparam logic [3:0] MODE_NOP  = 4'd0;
	localparam logic [3:0] MODE_ADD  = 4'd1;
	localparam logic [3:0] MODE_SUB  = 4'd2;
	localparam logic [3:0] MODE_MUL  = 4'd3;
	localparam logic [3:0] MODE_DIV  = 4'd4;
	localparam logic [3:0] MODE_AND  = 4'd5;
	localparam logic [3:0] MODE_OR   = 4'd6;
	localparam logic [3:0] MODE_NOT  = 4'd7;
	localparam logic [3:0] MODE_EQ   = 4'd8;
	localparam logic [3:0] MODE_NE   = 4'd9;
	localparam logic [3:0] MODE_LT   = 4'd10;
	localparam logic [3:0] MODE_LE   = 4'd11;
	localparam logic [3:0] MODE_GT   = 4'd12;
	localparam logic [3:0] MODE_GE   = 4'd13;
	localparam logic [3:0] MODE_PUSH = 4'd14;
	localparam logic [3:0] MODE_ZERO = 4'd15;

	typedef struct packed {
		logic              start;
		logic [3:0]        mode;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		logic [DATA_W-1:0] imm_a;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] result;
	} alu_rsp_t;

endpackage
`default_nettype wire

[design/vbse_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module vbse_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[design/vbse_alu.sv]
`timescale 1ns / 1ps
`default_nettype none
module vbse_alu (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire vbse_pkg::alu_req_t req,
	output vbse_pkg::alu_rsp_t    rsp
);
	import vbse_pkg::*;

	localparam logic [1:0] K_MUL = 2'd1;
	localparam logic [1:0] K_DIV = 2'd2;
	localparam logic [6:0] DIV_LAST = 7'(DATA_W);

	logic              busy_q, done_q, neg_q;
	logic [1:0]        kind_q;
	logic [6:0]        step_q;
	logic [DATA_W-1:0] a_q, b_q, acc_q, prod_q, rem_q, dvd_q, res_q;
	logic [31:0]       mx, my;
	logic [DATA_W:0]   trial;
	logic              qbit;

	// simple (non-iterative) operations
	function automatic logic [DATA_W-1:0] simple_op(input logic [3:0] m,
		input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
		input logic [DATA_W-1:0] ia);
		logic r;
		r = 1'b0;
		case (m)
			MODE_ADD:  return a + b;
			MODE_SUB:  return a - b;
			MODE_PUSH: return ia;
			MODE_AND:  r = (a != '0) && (b != '0);
			MODE_OR:   r = (a != '0) || (b != '0);
			MODE_NOT:  r = (a == '0);
			MODE_EQ:   r = (a == b);
			MODE_NE:   r = (a != b);
			MODE_LT:   r = $signed(a) < $signed(b);
			MODE_LE:   r = $signed(a) <= $signed(b);
			MODE_GT:   r = $signed(a) > $signed(b);
			MODE_GE:   r = $signed(a) >= $signed(b);
			default:   r = 1'b0;
		endcase
		return {{(DATA_W-1){1'b0}}, r};
	endfunction

	// shared 32x32 multiplier operand select
	always_comb begin
		case (step_q[1:0])
			2'd0:    begin mx = a_q[31:0];  my = b_q[31:0];  end
			2'd1:    begin mx = a_q[31:0];  my = b_q[63:32]; end
			default: begin mx = a_q[63:32]; my = b_q[31:0];  end
		endcase
	end

	// restoring divide step on magnitudes
	assign trial = {rem_q, dvd_q[DATA_W-1]} - {1'b0, b_q};
	assign qbit  = ~trial[DATA_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			kind_q <= '0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				step_q <= '0;
				if (req.mode == MODE_MUL) begin
					busy_q <= 1'b1;
					kind_q <= K_MUL;
				end else if (req.mode == MODE_DIV && req.b != '0) begin
					busy_q <= 1'b1;
					kind_q <= K_DIV;
				end else begin
					done_q <= 1'b1;
				end
			end else if (busy_q) begin
				step_q <= step_q + 7'd1;
				if ((kind_q == K_MUL && step_q == 7'd3) ||
				    (kind_q == K_DIV && step_q == DIV_LAST)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			if (req.mode == MODE_DIV) begin
				neg_q <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
				dvd_q <= req.a[DATA_W-1] ? (DATA_W'(0) - req.a) : req.a;
				b_q   <= req.b[DATA_W-1] ? (DATA_W'(0) - req.b) : req.b;
				res_q <= '0;
			end else begin
				a_q   <= req.a;
				b_q   <= req.b;
				res_q <= simple_op(req.mode, req.a, req.b, req.imm_a);
			end
		end else if (busy_q && kind_q == K_MUL) begin
			prod_q <= mx * my;
			case (step_q[1:0])
				2'd1:    acc_q <= prod_q;
				2'd2:    acc_q <= acc_q + {prod_q[31:0], 32'b0};
				2'd3:    res_q <= acc_q + {prod_q[31:0], 32'b0};
				default: acc_q <= acc_q;
			endcase
		end else if (busy_q && kind_q == K_DIV) begin
			if (step_q == DIV_LAST) begin
				res_q <= neg_q ? (DATA_W'(0) - dvd_q) : dvd_q;
			end else begin
				rem_q <= qbit ? trial[DATA_W-1:0] : {rem_q[DATA_W-2:0], dvd_q[DATA_W-1]};
				dvd_q <= {dvd_q[DATA_W-2:0], qbit};
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;
endmodule
`default_nettype wire

[design/vliw_bundle_slot_executor.sv]
// Flow: a slot is accepted, its operands are read, and the ALU executes it
// (simple operations directly, multiply on a shared 32x32 multiplier in
// partial steps, divide one quotient bit per cycle); the result then waits
// for the output register. A commit then walks the write buffer.
// Throughput: one slot at a time; next slot taken after result and commit.
// Reset: register file reads as zero (per-entry valid bits), buffer empty.
`timescale 1ns / 1ps
`default_nettype none
module vliw_bundle_slot_executor (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  mode,
	input  wire logic [15:0] src_a_index,
	input  wire logic [15:0] src_b_index,
	input  wire logic [63:0] imm_a,
	input  wire logic [63:0] imm_b,
	input  wire logic [15:0] dest_index,
	input  wire logic        write_enable,
	input  wire logic        last_in_bundle,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      result_value,
	output logic [15:0]      result_dest,
	output logic             result_writes,
	output logic             bundle_committed
);
	import vbse_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_OPND = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_OUT  = 3'd3;
	localparam logic [2:0] ST_CMT  = 3'd4;

	logic [2:0]         state_q;
	logic [3:0]         mode_q;
	logic [FIELD_W-1:0] sa_q, sb_q, dest_q;
	logic [DATA_W-1:0]  imma_q, immb_q, res_q;
	logic               we_q, last_q;
	logic               vld_q [REG_COUNT];
	logic [RA_W-1:0]    pdest_q [MAX_SLOTS];
	logic [DATA_W-1:0]  pval_q [MAX_SLOTS];
	logic [CNT_W-1:0]   cnt_q, cmt_idx_q, cnt_next;
	logic               out_valid_q;

	logic [DATA_W-1:0]  rd_a, rd_b, op_a, op_b;
	logic               ram_we, accept, out_free, do_write, do_commit;
	logic [RA_W-1:0]    ram_waddr;
	logic [DATA_W-1:0]  ram_wdata;
	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// two mirrored copies of the register file give two read ports
	assign ram_we    = (state_q == ST_CMT) && (cmt_idx_q < cnt_q);
	assign ram_waddr = pdest_q[cmt_idx_q[PI_W-1:0]];
	assign ram_wdata = pval_q[cmt_idx_q[PI_W-1:0]];

	vbse_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_a (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(src_a_index[RA_W-1:0]), .rdata(rd_a)
	);
	vbse_ram #(.WIDTH(DATA_W), .DEPTH(REG_COUNT)) u_rf_b (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(src_b_index[RA_W-1:0]), .rdata(rd_b)
	);

	// operand select: register (zero if never written) or immediate
	always_comb begin
		if (sa_q < FIELD_W'(REG_COUNT)) begin
			op_a = vld_q[sa_q[RA_W-1:0]] ? rd_a : '0;
		end else begin
			op_a = imma_q;
		end
		if (sb_q < FIELD_W'(REG_COUNT)) begin
			op_b = vld_q[sb_q[RA_W-1:0]] ? rd_b : '0;
		end else begin
			op_b = immb_q;
		end
	end

	assign alu_req.start = (state_q == ST_OPND);
	assign alu_req.mode  = mode_q;
	assign alu_req.a     = op_a;
	assign alu_req.b     = op_b;
	assign alu_req.imm_a = imma_q;

	vbse_alu u_alu (.clk(clk), .arst_n(arst_n), .req(alu_req), .rsp(alu_rsp));

	// buffer and commit decisions for the current slot
	assign do_write  = (mode_q != MODE_NOP) && we_q && (dest_q < FIELD_W'(REG_COUNT));
	assign cnt_next  = cnt_q + CNT_W'(do_write);
	assign do_commit = last_q || (cnt_next == CNT_W'(MAX_SLOTS));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			cmt_idx_q   <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < REG_COUNT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			// result valid: set on a new result, cleared on transfer out
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (accept) state_q <= ST_OPND;
				ST_OPND: state_q <= ST_EXEC;
				ST_EXEC: if (alu_rsp.done) state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						cnt_q       <= cnt_next;
						cmt_idx_q   <= '0;
						state_q     <= do_commit ? ST_CMT : ST_IDLE;
					end
				end
				ST_CMT: begin
					if (cmt_idx_q < cnt_q) begin
						vld_q[ram_waddr] <= 1'b1;
						cmt_idx_q        <= cmt_idx_q + CNT_W'(1);
					end else begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			sa_q   <= src_a_index;
			sb_q   <= src_b_index;
			imma_q <= imm_a;
			immb_q <= imm_b;
			dest_q <= dest_index;
			we_q   <= write_enable;
			last_q <= last_in_bundle;
		end
		if (state_q == ST_EXEC && alu_rsp.done) begin
			res_q <= (mode_q == MODE_NOP) ? '0 : alu_rsp.result;
		end
		if (state_q == ST_OUT && out_free) begin
			result_value     <= res_q;
			result_dest      <= dest_q;
			result_writes    <= do_write;
			bundle_committed <= do_commit;
			if (do_write) begin
				pdest_q[cnt_q[PI_W-1:0]] <= dest_q[RA_W-1:0];
				pval_q[cnt_q[PI_W-1:0]]  <= res_q;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

[design/vbse_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "vliw_bundle_slot_executor_defines.svh"
module vbse_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] result_value,
	input wire logic [15:0] result_dest,
	input wire logic        result_writes
);
	import vbse_pkg::*;

	// stalled result holds
	`VBSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(result_dest), "result changed while stalled")
	// one slot at a time: busy after a transfer in
	`VBSE_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "slot taken while busy")
	// a buffered write always targets an existing register
	`VBSE_ASSERT_NOW(a_write_dest, out_valid && result_writes, result_dest < 16'(REG_COUNT), "write to missing register")
endmodule

bind vliw_bundle_slot_executor vbse_checker u_vbse_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .result_value(result_value),
	.result_dest(result_dest), .result_writes(result_writes)
);
`default_nettype wire

[test/vliw_bundle_slot_executor_checker.sv]
`timescale 1ns / 1ps
module vliw_bundle_slot_executor_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [3:0]  mode,
	input  wire logic [15:0] src_a_index,
	input  wire logic [15:0] src_b_index,
	input  wire logic [63:0] imm_a,
	input  wire logic [63:0] imm_b,
	input  wire logic [15:0] dest_index,
	input  wire logic        write_enable,
	input  wire logic        last_in_bundle,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [63:0] result_value,
	input  wire logic [15:0] result_dest,
	input  wire logic        result_writes,
	input  wire logic        bundle_committed,
	output int               fail_count,
	output int               pending_results
);
	import vbse_pkg::*;

	typedef struct packed {
		logic [63:0] value;
		logic [15:0] dest;
		logic        writes;
		logic        committed;
	} slot_result_t;

	// architectural model state
	logic [63:0] regs [REG_COUNT];
	logic [15:0] wbuf_dest [MAX_SLOTS];
	logic [63:0] wbuf_value [MAX_SLOTS];
	int wbuf_count;
	slot_result_t slot_q[$];

	assign pending_results = slot_q.size();

	function automatic logic [63:0] exec_op(logic [3:0] op, logic [63:0] a, logic [63:0] b,
			logic [63:0] ia);
		logic signed [63:0] sa, sb;
		sa = a;
		sb = b;
		case (op)
			MODE_ADD: return a + b;
			MODE_SUB: return a - b;
			MODE_MUL: return a * b;
			MODE_DIV: begin
				// zero divisor gives zero; min / -1 wraps to min
				if (b == 0) return 0;
				if (a == 64'h8000_0000_0000_0000 && b == '1) return a;
				return sa / sb;
			end
			MODE_AND: return 64'((a != 0) && (b != 0));
			MODE_OR:  return 64'((a != 0) || (b != 0));
			MODE_NOT: return 64'(a == 0);
			MODE_EQ:  return 64'(a == b);
			MODE_NE:  return 64'(a != b);
			MODE_LT:  return 64'(sa < sb);
			MODE_LE:  return 64'(sa <= sb);
			MODE_GT:  return 64'(sa > sb);
			MODE_GE:  return 64'(sa >= sb);
			MODE_PUSH: return ia;
			default:  return 0;
		endcase
	endfunction

	// predict on each input transfer
	always @(posedge clk or negedge arst_n) begin
		slot_result_t r;
		logic [63:0] a, b;
		if (!arst_n) begin
			foreach (regs[i]) regs[i] = '0;
			wbuf_count = 0;
			slot_q.delete();
		end else if (in_valid && in_ready) begin
			a = (src_a_index < REG_COUNT) ? regs[src_a_index] : imm_a;
			b = (src_b_index < REG_COUNT) ? regs[src_b_index] : imm_b;
			r = '0;
			r.dest = dest_index;
			if (mode != MODE_NOP) begin
				r.value = exec_op(mode, a, b, imm_a);
				if (write_enable && dest_index < REG_COUNT && wbuf_count < MAX_SLOTS) begin
					wbuf_dest[wbuf_count] = dest_index;
					wbuf_value[wbuf_count] = r.value;
					wbuf_count++;
					r.writes = 1'b1;
				end
			end
			if (last_in_bundle || wbuf_count >= MAX_SLOTS) begin
				for (int i = 0; i < wbuf_count; i++) regs[wbuf_dest[i]] = wbuf_value[i];
				wbuf_count = 0;
				r.committed = 1'b1;
			end
			slot_q = {slot_q, r};
		end
	end

	// compare on each output transfer
	always @(posedge clk or negedge arst_n) begin
		slot_result_t e;
		if (!arst_n) begin
			fail_count = 0;
		end else if (out_valid && out_ready) begin
			#0;
			if (slot_q.size() == 0) begin
				$display("%0t: unexpected result value=%h", $time, result_value);
				fail_count++;
			end else begin
				e = slot_q.pop_front();
				if (e.value !== result_value) begin
					$display("%0t: value exp %h got %h", $time, e.value, result_value);
					fail_count++;
				end
				if (e.dest !== result_dest) begin
					$display("%0t: dest exp %h got %h", $time, e.dest, result_dest);
					fail_count++;
				end
				if (e.writes !== result_writes) begin
					$display("%0t: writes exp %b got %b", $time, e.writes, result_writes);
					fail_count++;
				end
				if (e.committed !== bundle_committed) begin
					$display("%0t: committed exp %b got %b", $time, e.committed,
						bundle_committed);
					fail_count++;
				end
			end
		end
	end

endmodule

[test/tb_vliw_bundle_slot_executor.sv]
`timescale 1ns / 1ps
module tb_vliw_bundle_slot_executor;
	import vbse_pkg::*;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [3:0] mode;
	logic [15:0] src_a_index, src_b_index, dest_index;
	logic [63:0] imm_a, imm_b;
	logic write_enable, last_in_bundle;
	logic [63:0] result_value;
	logic [15:0] result_dest;
	logic result_writes, bundle_committed;
	int fail_count, pending_results;
	int cycle_count;
	bit long_hold;

	localparam int CYCLE_LIMIT = 2_000_000;

	vliw_bundle_slot_executor dut (.*);
	vliw_bundle_slot_executor_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// receiver stall pattern with a long hold-off whenever requested
	initial begin
		int phase;
		out_ready = 0;
		phase = 0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready <= 0;
				repeat (400) @(negedge clk);
				long_hold = 0;
			end
			phase++;
			if ((phase / 300) % 3 == 0) out_ready <= 1;
			else if ((phase / 300) % 3 == 1) out_ready <= ($urandom_range(0, 3) != 0);
			else out_ready <= ($urandom_range(0, 1) != 0);
		end
	end

	function automatic logic [63:0] pick_imm();
		case ($urandom_range(0, 7))
			0: return 64'h8000_0000_0000_0000;
			1: return 64'h7fff_ffff_ffff_ffff;
			2: return '1;
			3: return 0;
			4: return 64'($urandom_range(0, 20));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [15:0] pick_index();
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(REG_COUNT, 65535));
			1: return 16'hffff;
			2: return 16'(REG_COUNT);
			default: return 16'($urandom_range(0, REG_COUNT - 1));
		endcase
	endfunction

	task automatic send_slot(logic [3:0] op, logic [15:0] sa, logic [15:0] sb,
			logic [63:0] ia, logic [63:0] ib, logic [15:0] d, logic we, logic last);
		in_valid <= 1;
		mode <= op;
		src_a_index <= sa;
		src_b_index <= sb;
		imm_a <= ia;
		imm_b <= ib;
		dest_index <= d;
		write_enable <= we;
		last_in_bundle <= last;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_random_slot(logic last);
		logic [3:0] op;
		op = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
			4'($urandom_range(1, 14));
		// keep divides rare, they are slow
		if (op == MODE_DIV && $urandom_range(0, 2) != 0) op = MODE_ADD;
		send_slot(op, pick_index(), pick_index(), pick_imm(), pick_imm(),
			($urandom_range(0, 7) == 0) ? 16'($urandom_range(REG_COUNT, 65535))
				: 16'($urandom_range(0, REG_COUNT - 1)),
			$urandom_range(0, 4) != 0, last);
	endtask

	task automatic idle_line();
		in_valid <= 0;
	endtask

	initial begin
		int sent, len;
		logic [15:0] ext;
		long_hold = 0;
		arst_n = 0;
		in_valid = 0;
		mode = MODE_NOP;
		src_a_index = 0;
		src_b_index = 0;
		imm_a = 0;
		imm_b = 0;
		dest_index = 0;
		write_enable = 0;
		last_in_bundle = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		ext = 16'(REG_COUNT);

		// directed: every op on immediates, plus the corner cases
		for (int op = 0; op < 16; op++)
			send_slot(4'(op), 16'hffff, ext, 64'h8000_0000_0000_0000, '1,
				16'(op), 1'b1, 1'b0);
		send_slot(MODE_DIV, ext, ext, 64'd7, 64'd0, 16'd1, 1'b1, 1'b0);
		send_slot(MODE_DIV, ext, ext, -64'sd7, 64'd2, 16'd2, 1'b1, 1'b1);
		send_slot(MODE_MUL, ext, ext, '1, 64'h7fff_ffff_ffff_ffff, 16'hffff, 1'b1, 1'b1);
		send_slot(MODE_ADD, 16'd1, 16'd2, 0, 0, 16'd3, 1'b1, 1'b0);
		send_slot(MODE_PUSH, ext, ext, 64'd5, 0, 16'd3, 1'b1, 1'b0);
		send_slot(MODE_ADD, 16'd3, 16'd3, 0, 0, 16'd3, 1'b1, 1'b1);
		send_slot(MODE_NOP, 16'd0, 16'd0, 0, 0, 16'd4, 1'b1, 1'b1);
		idle_line();

		// random bundles, bursts and gaps
		sent = 0;
		while (sent < 1950) begin
			len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++) begin
				send_random_slot(i == len - 1 || $urandom_range(0, 9) == 0);
				sent++;
			end
			if ($urandom_range(0, 2) == 0) begin
				idle_line();
				repeat ($urandom_range(1, 20)) @(negedge clk);
			end
			if (sent > 600 && sent < 615) long_hold = 1;
			if (sent > 1200 && sent < 1213) begin
				idle_line();
				do @(negedge clk); while (pending_results != 0);
			end
		end
		idle_line();

		while (pending_results != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (fail_count == 0 && pending_results == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule
